// ===== rtl/twmsh_pkg.sv =====
package twmsh_pkg;

   localparam int unsigned BLOCK_BYTES = 12;
   localparam int unsigned FILL_W      = 4;
   localparam int unsigned MIX_ROWS    = 9;
   localparam int unsigned ROW_W       = 4;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;
   localparam int unsigned QUEUE_CNT_W = 3;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [31:0] GOLDEN_WORD       = 32'h9e3779b9;
   localparam logic [31:0] SEED_RESET        = 32'hdeadbeef;
   localparam logic [5:0]  BUCKET_BITS_RESET = 6'd8;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_VALUE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUCKET_BITS   = 1'b1;

   typedef struct packed {
      logic [7:0] key_byte;
      logic       byte_present;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] hash_value;
      logic [31:0] bucket_index;
   } rsp_type;

   // Work passed from the byte assembler to the mixer
   typedef struct packed {
      logic        first;     // first job of a key: start from golden words and seed
      logic [31:0] seed;
      logic [31:0] word_a;
      logic [31:0] word_b;
      logic [31:0] word_c;    // tail job: already holds the key length
      logic        block;     // words are a complete 12-byte block
      logic        finish;    // key ends with this job
      logic [31:0] key_len;
   } job_type;

endpackage

// ===== rtl/twmsh_front.sv =====
module twmsh_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  twmsh_pkg::req_type req_item,
   input  logic [31:0]        initial_value,
   input  logic               queue_full,
   output logic               job_push,
   output twmsh_pkg::job_type job_data
);
   import twmsh_pkg::*;

   logic [7:0]        byte_ff [BLOCK_BYTES];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [31:0]       len_ff, len_in;
   logic [31:0]       seed_ff, seed_in;
   logic              first_ff, first_in;

   logic              accept;
   logic [FILL_W-1:0] new_fill;
   logic              full_block;
   logic [31:0]       len_new;
   logic [31:0]       seed_eff;
   logic [7:0]        view [BLOCK_BYTES];
   logic [7:0]        vmask [BLOCK_BYTES];
   logic [31:0]       tail_c;
   logic [31:0]       blk_c;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   assign new_fill   = fill_ff + FILL_W'(req_item.byte_present);
   assign full_block = (new_fill == FILL_W'(BLOCK_BYTES));
   assign len_new    = len_ff + 32'(req_item.byte_present);
   assign seed_eff   = (len_ff == 32'd0) ? initial_value : seed_ff;

   // Buffer as it stands with the incoming byte in place
   always_comb begin
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         view[i]  = (req_item.byte_present && (fill_ff == FILL_W'(i))) ?
                    req_item.key_byte : byte_ff[i];
         vmask[i] = (FILL_W'(i) < new_fill) ? view[i] : 8'h00;
      end
   end

   assign blk_c  = {vmask[11], vmask[10], vmask[9], vmask[8]};
   assign tail_c = {vmask[10], vmask[9], vmask[8], 8'h00};

   always_comb begin
      job_push         = accept && (full_block || req_item.last_byte);
      job_data.first   = first_ff;
      job_data.seed    = seed_eff;
      job_data.word_a  = {vmask[3], vmask[2], vmask[1], vmask[0]};
      job_data.word_b  = {vmask[7], vmask[6], vmask[5], vmask[4]};
      job_data.word_c  = full_block ? blk_c : (tail_c + len_new);
      job_data.block   = full_block;
      job_data.finish  = req_item.last_byte;
      job_data.key_len = len_new;
   end

   always_comb begin
      fill_in  = fill_ff;
      len_in   = len_ff;
      seed_in  = seed_ff;
      first_in = first_ff;
      if (accept) begin
         seed_in = seed_eff;
         if (req_item.byte_present) begin
            len_in  = len_new;
            fill_in = full_block ? '0 : new_fill;
         end
         if (job_push) begin
            first_in = 1'b0;
         end
         // a finished key starts over
         if (req_item.last_byte) begin
            fill_in  = '0;
            len_in   = '0;
            first_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         len_ff   <= '0;
         first_ff <= 1'b1;
      end else begin
         fill_ff  <= fill_in;
         len_ff   <= len_in;
         first_ff <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_ff <= seed_in;
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         if (accept && req_item.byte_present && (fill_ff == FILL_W'(i))) begin
            byte_ff[i] <= req_item.key_byte;
         end
      end
   end

endmodule

// ===== rtl/twmsh_queue.sv =====
module twmsh_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  twmsh_pkg::job_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output twmsh_pkg::job_type head_data
);
   import twmsh_pkg::*;

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/twmsh_back.sv =====
module twmsh_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  twmsh_pkg::job_type job_data,
   output logic               job_pop,
   input  logic [5:0]         bucket_bits,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output twmsh_pkg::rsp_type rsp_item
);
   import twmsh_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIX,
      ST_ADD_LEN,
      ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [31:0]      a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic             block_ff, block_in;
   logic             finish_ff, finish_in;
   logic [31:0]      len_ff, len_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [31:0]      ma, mb, mc;
   logic [31:0]      mask;
   logic             out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign mask     = (bucket_bits >= 6'd32) ? 32'hffffffff :
                     ~(32'hffffffff << bucket_bits[4:0]);

   // One row of the mix per cycle
   always_comb begin
      ma = a_ff;
      mb = b_ff;
      mc = c_ff;
      unique case (row_ff)
         4'd0: ma = (a_ff - b_ff - c_ff) ^ (c_ff >> 13);
         4'd1: mb = (b_ff - c_ff - a_ff) ^ (a_ff << 8);
         4'd2: mc = (c_ff - a_ff - b_ff) ^ (b_ff >> 13);
         4'd3: ma = (a_ff - b_ff - c_ff) ^ (c_ff >> 12);
         4'd4: mb = (b_ff - c_ff - a_ff) ^ (a_ff << 16);
         4'd5: mc = (c_ff - a_ff - b_ff) ^ (b_ff >> 5);
         4'd6: ma = (a_ff - b_ff - c_ff) ^ (c_ff >> 3);
         4'd7: mb = (b_ff - c_ff - a_ff) ^ (a_ff << 10);
         4'd8: mc = (c_ff - a_ff - b_ff) ^ (b_ff >> 15);
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      block_in     = block_ff;
      finish_in    = finish_ff;
      len_in       = len_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      job_pop      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop   = 1'b1;
               a_in      = (job_data.first ? GOLDEN_WORD : a_ff) + job_data.word_a;
               b_in      = (job_data.first ? GOLDEN_WORD : b_ff) + job_data.word_b;
               c_in      = (job_data.first ? job_data.seed : c_ff) + job_data.word_c;
               block_in  = job_data.block;
               finish_in = job_data.finish;
               len_in    = job_data.key_len;
               row_in    = '0;
               state_in  = ST_MIX;
            end
         end
         ST_MIX: begin
            a_in = ma;
            b_in = mb;
            c_in = mc;
            if (row_ff == ROW_W'(MIX_ROWS - 1)) begin
               if (block_ff && finish_ff) begin
                  state_in = ST_ADD_LEN;
               end else if (finish_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         ST_ADD_LEN: begin
            // key ended on a full block: add the length alone, mix again
            c_in     = c_ff + len_ff;
            block_in = 1'b0;
            row_in   = '0;
            state_in = ST_MIX;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.hash_value   = c_ff;
               rsp_in.bucket_index = c_ff & mask;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff    <= row_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      block_ff  <= block_in;
      finish_ff <= finish_in;
      len_ff    <= len_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== rtl/three_word_mix_string_hash.sv =====
// Streaming three-word mix string hash, 32 bits, one key byte per item.
// Feed a key in order with byte_present set; mark its final item with
// last_byte (an item with last_byte and no byte closes an empty key) and one
// item comes back with hash_value and its bucket_index. The byte assembler
// takes one item per cycle; it stalls only when its four-entry job queue is
// full. For each job the mixer adds the words into a, b and c, then runs nine
// mix rows; at a key's end it adds the length and runs the nine rows again if
// the key ended exactly on a block boundary, then loads the result register.
// The queue lets the assembler take new bytes while the mixer is busy with
// an earlier job; when the mixer falls behind, the queue fills and intake
// stalls, so runs of short keys can be held back by the mixer. initial_value
// is the seed of word c: written before a key's first byte it applies to that
// key, written later to the next key. bucket_bits of 0 gives bucket_index 0,
// 32 or more keeps all bits.
module three_word_mix_string_hash (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  twmsh_pkg::req_type                      req_item,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output twmsh_pkg::rsp_type                      rsp_item,
   input  logic                                    csr_write_en,
   input  logic [twmsh_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [twmsh_pkg::CSR_DATA_W-1:0]        csr_write_data
);
   import twmsh_pkg::*;

   // Configuration registers
   logic [31:0] initial_value_ff, initial_value_in;
   logic [5:0]  bucket_bits_ff, bucket_bits_in;

   // Front to queue to back
   logic        job_push;
   job_type     push_data;
   logic        queue_full;
   logic        job_pop;
   logic        head_valid;
   job_type     head_data;

   // Decode register writes; hold otherwise
   always_comb begin
      initial_value_in = initial_value_ff;
      bucket_bits_in   = bucket_bits_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_INITIAL_VALUE: initial_value_in = csr_write_data[31:0];
            CSR_BUCKET_BITS:   bucket_bits_in   = csr_write_data[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_value_ff <= SEED_RESET;
         bucket_bits_ff   <= BUCKET_BITS_RESET;
      end else begin
         initial_value_ff <= initial_value_in;
         bucket_bits_ff   <= bucket_bits_in;
      end
   end

   // Front: collect bytes, cut full blocks and key tails into jobs
   twmsh_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_item      (req_item),
      .initial_value (initial_value_ff),
      .queue_full    (queue_full),
      .job_push      (job_push),
      .job_data      (push_data)
   );

   // Queue: decouple byte intake from the multi-cycle mix
   twmsh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // Back: add words, mix one row per cycle, emit the finished hash
   twmsh_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (head_valid),
      .job_data    (head_data),
      .job_pop     (job_pop),
      .bucket_bits (bucket_bits_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

endmodule
